// ----- rtl/route_request_dedup_table_macros.svh -----
// Assertion helpers shared by the RTL files.
`ifndef ROUTE_REQUEST_DEDUP_TABLE_MACROS_SVH
`define ROUTE_REQUEST_DEDUP_TABLE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RRDT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RRDT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rrdt_pkg.sv -----
package rrdt_pkg;

  // Table geometry.
  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // Idle limit after reset, in microseconds.
  localparam logic [31:0] IDLE_RESET = 32'd10000000;

  // One route request as it arrives on the input channel.
  typedef struct packed {
    logic [63:0] orig_addr_hi;
    logic [63:0] orig_addr_lo;
    logic [63:0] targ_addr_hi;
    logic [63:0] targ_addr_lo;
    logic [7:0]  metric_kind;
    logic [7:0]  route_metric;
    logic [15:0] seq_number;
    logic [47:0] packet_time;
    logic [47:0] current_time;
  } req_t;

  // One verdict on the result channel.
  typedef struct packed {
    logic redundant;
    logic stored_new;
    logic dropped_full;
  } rsp_t;

  // One table entry as held in the entry memory.
  typedef struct packed {
    logic [63:0] orig_hi;
    logic [63:0] orig_lo;
    logic [63:0] targ_hi;
    logic [63:0] targ_lo;
    logic [7:0]  metric_kind;
    logic [7:0]  metric;
    logic [15:0] seq;
    logic [47:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Verdict of the shared compare unit on one entry.
  typedef struct packed {
    logic stale;
    logic key_eq;
  } cmp_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

endpackage

// ----- rtl/rrdt_ram.sv -----
module rrdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/rrdt_cmp.sv -----
module rrdt_cmp (
  input  rrdt_pkg::entry_t ent,
  input  rrdt_pkg::req_t   req,
  input  logic [31:0]      idle_limit,
  output rrdt_pkg::cmp_t   res
);

  logic [48:0] expiry;

  // An entry is stale once its stamp plus the idle limit lies before now.
  assign expiry = {1'b0, ent.stamp} + {17'd0, idle_limit};
  assign res.stale = (expiry < {1'b0, req.current_time});

  // The key is both addresses and the metric type.
  assign res.key_eq = (ent.orig_hi == req.orig_addr_hi) &&
                      (ent.orig_lo == req.orig_addr_lo) &&
                      (ent.targ_hi == req.targ_addr_hi) &&
                      (ent.targ_lo == req.targ_addr_lo) &&
                      (ent.metric_kind == req.metric_kind);

endmodule

// ----- rtl/route_request_dedup_table.sv -----
// Channel   Direction  Payload         Handshake
// in_       input      rrdt_pkg::req_t in_valid / in_ready
// out_      output     rrdt_pkg::rsp_t out_valid / out_ready
// cfg_      input      32-bit limit    cfg_wr_en, no wait
//
// The result beat is offered once the scan ends at a matching entry or at the last
// entry and the update has gone through; the sequencer then returns to idle, where
// the next request can be taken. The entry memory is read one entry per cycle and
// each entry passes the one shared compare unit, so the scan length sets the time
// that a request occupies the block.
// Reset clears every valid bit at once; no clearing pass is needed.
// A finished result waits in the output register; a new request may be taken
// meanwhile, and its update stalls until the earlier beat has gone.
`include "route_request_dedup_table_macros.svh"

module route_request_dedup_table (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rrdt_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rrdt_pkg::rsp_t out_data,
  input  logic           cfg_wr_en,
  input  logic [31:0]    cfg_wr_data
);

  localparam int IDX_W = rrdt_pkg::IDX_W;

  rrdt_pkg::state_t state_r, state_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic             free_found_r, free_found_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic [15:0]      hit_seq_r, hit_seq_nxt;
  logic [7:0]       hit_metric_r, hit_metric_nxt;
  rrdt_pkg::req_t   req_r, req_nxt;
  logic [31:0]      idle_r, idle_nxt;
  logic [rrdt_pkg::TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic             out_valid_r, out_valid_nxt;
  rrdt_pkg::rsp_t   out_data_r, out_data_nxt;

  logic             in_acc;
  logic [IDX_W-1:0] rd_addr;
  rrdt_pkg::entry_t rd_ent;
  rrdt_pkg::entry_t wr_ent;
  logic             ram_we;
  logic [IDX_W-1:0] wr_addr;
  rrdt_pkg::cmp_t   cmp_res;
  logic             cur_live;
  logic             hit_now;
  logic [15:0]      seq_diff;
  logic             seq_eq;
  logic             seq_older;
  logic             upd_go;
  rrdt_pkg::rsp_t   verdict;

  assign in_acc   = in_valid && in_ready;
  assign in_ready = (state_r == rrdt_pkg::ST_IDLE);

  // During the scan the next entry is fetched while the current one is judged.
  always_comb begin
    rd_addr = '0;
    if (state_r == rrdt_pkg::ST_SCAN && cur_r != rrdt_pkg::LAST_IDX) begin
      rd_addr = cur_r + 1'b1;
    end
  end

  rrdt_ram #(
    .WIDTH(rrdt_pkg::ENTRY_W),
    .DEPTH(rrdt_pkg::TABLE_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_addr),
    .wdata(wr_ent),
    .raddr(rd_addr),
    .rdata(rd_ent)
  );

  rrdt_cmp u_cmp (
    .ent       (rd_ent),
    .req       (req_r),
    .idle_limit(idle_r),
    .res       (cmp_res)
  );

  // An entry survives ageing only if valid and not stale.
  assign cur_live = valid_r[cur_r] && !cmp_res.stale;
  assign hit_now  = cur_live && cmp_res.key_eq;

  // Sequence order under 16-bit wrap; half the circle and beyond is older.
  assign seq_diff  = req_r.seq_number - hit_seq_r;
  assign seq_eq    = (seq_diff == 16'd0);
  assign seq_older = seq_diff[15];

  assign upd_go = (state_r == rrdt_pkg::ST_UPD) && (!out_valid_r || out_ready);

  // Entry write: refresh on a match, fresh insert into the lowest free slot.
  always_comb begin
    wr_ent.orig_hi     = req_r.orig_addr_hi;
    wr_ent.orig_lo     = req_r.orig_addr_lo;
    wr_ent.targ_hi     = req_r.targ_addr_hi;
    wr_ent.targ_lo     = req_r.targ_addr_lo;
    wr_ent.metric_kind = req_r.metric_kind;
    wr_ent.metric      = req_r.route_metric;
    wr_ent.seq         = req_r.seq_number;
    wr_ent.stamp       = req_r.packet_time;
    wr_addr            = free_idx_r;
    if (hit_r) begin
      wr_addr      = hit_idx_r;
      wr_ent.stamp = req_r.current_time;
      if (!seq_eq) begin
        wr_ent.metric = hit_metric_r;
      end
      if (seq_eq || seq_older) begin
        wr_ent.seq = hit_seq_r;
      end
    end
  end

  assign ram_we = upd_go && (hit_r || free_found_r);

  // Verdict for the result beat.
  always_comb begin
    verdict.redundant    = 1'b0;
    verdict.stored_new   = 1'b0;
    verdict.dropped_full = 1'b0;
    if (hit_r) begin
      verdict.redundant = seq_older || (seq_eq && (hit_metric_r <= req_r.route_metric));
    end else if (free_found_r) begin
      verdict.stored_new = 1'b1;
    end else begin
      verdict.dropped_full = 1'b1;
    end
  end

  // Sequencer, scan bookkeeping, valid bits and output register.
  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    hit_seq_nxt    = hit_seq_r;
    hit_metric_nxt = hit_metric_r;
    req_nxt        = req_r;
    idle_nxt       = idle_r;
    valid_nxt      = valid_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;

    if (cfg_wr_en) begin
      idle_nxt = cfg_wr_data;
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      rrdt_pkg::ST_IDLE: begin
        if (in_acc) begin
          req_nxt        = in_data;
          cur_nxt        = '0;
          hit_nxt        = 1'b0;
          free_found_nxt = 1'b0;
          state_nxt      = rrdt_pkg::ST_SCAN;
        end
      end
      rrdt_pkg::ST_SCAN: begin
        if (valid_r[cur_r] && cmp_res.stale) begin
          valid_nxt[cur_r] = 1'b0;
        end
        if (!cur_live && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = cur_r;
        end
        if (hit_now) begin
          hit_nxt        = 1'b1;
          hit_idx_nxt    = cur_r;
          hit_seq_nxt    = rd_ent.seq;
          hit_metric_nxt = rd_ent.metric;
          state_nxt      = rrdt_pkg::ST_UPD;
        end else if (cur_r == rrdt_pkg::LAST_IDX) begin
          state_nxt = rrdt_pkg::ST_UPD;
        end else begin
          cur_nxt = cur_r + 1'b1;
        end
      end
      rrdt_pkg::ST_UPD: begin
        if (upd_go) begin
          if (!hit_r && free_found_r) begin
            valid_nxt[free_idx_r] = 1'b1;
          end
          out_valid_nxt = 1'b1;
          out_data_nxt  = verdict;
          state_nxt     = rrdt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rrdt_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rrdt_pkg::ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      idle_r      <= rrdt_pkg::IDLE_RESET;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      idle_r      <= idle_nxt;
    end
  end

  // Payload and scan registers.
  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    hit_seq_r    <= hit_seq_nxt;
    hit_metric_r <= hit_metric_nxt;
    req_r        <= req_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks on the sequencer and the table.
  `RRDT_ASSERT_NEXT(a_accept_starts_scan, clk, rst_n, in_acc, (state_r == rrdt_pkg::ST_SCAN) && (cur_r == '0), "accepted request did not start a scan at entry zero")
  `RRDT_ASSERT_NOW(a_one_verdict, clk, rst_n, out_valid, $onehot0(out_data), "result beat carries more than one verdict flag")
  `RRDT_ASSERT_NEXT(a_insert_sets_valid, clk, rst_n, upd_go && !hit_r && free_found_r, valid_r[$past(free_idx_r)], "inserted entry not marked valid")
  `RRDT_ASSERT_NOW(a_write_only_in_update, clk, rst_n, ram_we, state_r == rrdt_pkg::ST_UPD && !(out_valid_r && !out_ready), "entry memory written outside an update")

endmodule
